FILE: sv/rthl_pkg.sv
// ----------------------------------------------------------------------------
// rthl_pkg: shared types, widths and tables
// Fixed-point formats, color form table, hue map and hue magnitudes for the
// RGB to hue/level palette index pipeline.
// ----------------------------------------------------------------------------
package rthl_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int BASE_BITS     = 24;
  localparam int SHIFT         = BASE_BITS - FRACTION_BITS;
  localparam logic [63:0] RND  = (64'd1 << SHIFT) >> 1;

  localparam int SUMW = 18;                  // r^2+g^2+b^2
  localparam int LW   = 9 + FRACTION_BITS;   // magnitude root width
  localparam int XW   = 2 * LW;              // scaled radicand width
  localparam int QW   = FRACTION_BITS + 2;   // normalized component width
  localparam int EW   = 2 * QW + 2;          // form error width
  localparam int TW   = LW + 4;              // level threshold width

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef logic [LW-1:0] root_t;
  typedef logic [QW-1:0] norm_t;

  typedef enum logic [2:0] {
    ORD_RGB = 3'd0,
    ORD_RBG = 3'd1,
    ORD_BRG = 3'd2,
    ORD_GRB = 3'd3,
    ORD_GBR = 3'd4,
    ORD_BGR = 3'd5
  } ord_e;

  localparam logic [63:0] K_ONE  = 64'd16777216;
  localparam logic [63:0] K_0875 = 64'd14680064;
  localparam logic [63:0] K_0484 = 64'd8122234;
  localparam logic [63:0] K_0707 = 64'd11863284;
  localparam logic [63:0] K_0667 = 64'd11184811;
  localparam logic [63:0] K_0527 = 64'd8842370;
  localparam logic [63:0] K_0577 = 64'd9686331;
  localparam logic [63:0] M_255  = 64'd4278190080;
  localparam logic [63:0] M_291  = 64'd4889360084;
  localparam logic [63:0] M_360  = 64'd6050274209;
  localparam logic [63:0] M_382  = 64'd6417284801;
  localparam logic [63:0] M_441  = 64'd7410042182;

  localparam logic [63:0] FORM_K [5][3] = '{
    '{K_ONE,  64'd0,  64'd0 },
    '{K_0875, K_0484, 64'd0 },
    '{K_0707, K_0707, 64'd0 },
    '{K_0667, K_0527, K_0527},
    '{K_0577, K_0577, K_0577}
  };

  localparam logic [3:0] HUE_MAP [6][5] = '{
    '{4'd12, 4'd14, 4'd10, 4'd15, 4'd0},
    '{4'd12, 4'd13, 4'd5,  4'd15, 4'd0},
    '{4'd1,  4'd4,  4'd5,  4'd6,  4'd0},
    '{4'd7,  4'd9,  4'd10, 4'd11, 4'd0},
    '{4'd7,  4'd8,  4'd3,  4'd11, 4'd0},
    '{4'd1,  4'd2,  4'd3,  4'd6,  4'd0}
  };

  localparam logic [63:0] HUE_MAG [16] = '{
    M_441, M_255, M_291, M_360, M_291, M_360, M_382,
    M_255, M_291, M_291, M_360, M_382,
    M_255, M_291, M_291, M_382
  };

  function automatic logic [63:0] to_frac(input logic [63:0] v);
    to_frac = (v + RND) >> SHIFT;
  endfunction

  function automatic norm_t form_val(input int f, input int j);
    logic [63:0] t;
    t = to_frac(FORM_K[f][j]);
    form_val = t[QW-1:0];
  endfunction

  function automatic root_t mag_frac(input logic [3:0] hue);
    logic [63:0] t;
    t = to_frac(HUE_MAG[hue]);
    mag_frac = t[LW-1:0];
  endfunction

endpackage

FILE: sv/rgb_to_hue_level_palette_index.sv
// ----------------------------------------------------------------------------
// rgb_to_hue_level_palette_index: RGB color to hue/level palette index
// Stages in order: the squares register, one stage per root bit, one per
// quotient bit, five to classify.
// Throughput is one transaction per cycle; a stalled output freezes the
// whole pipeline. Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hue_level_palette_index import rthl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] palette_index_o,
  output logic [3:0] hue_index_o,
  output logic [3:0] level_o
);

  logic            en;
  logic            v0_q;
  rgb_t            rgb0_q;
  logic [SUMW-1:0] sum_q;

  logic  sq_valid, dv_valid;
  rgb_t  sq_rgb, dv_rgb;
  root_t sq_root, dv_lq;
  logic [2:0][QW-1:0] dv_norm;

  // advance everything unless a finished result is held
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rgb0_q <= '{red: red_i, green: green_i, blue: blue_i};
      sum_q  <= SUMW'(red_i) * SUMW'(red_i) + SUMW'(green_i) * SUMW'(green_i)
              + SUMW'(blue_i) * SUMW'(blue_i);
    end
  end

  rthl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .rgb_i   (rgb0_q),
    .sum_i   (sum_q),
    .valid_o (sq_valid),
    .rgb_o   (sq_rgb),
    .root_o  (sq_root)
  );

  rthl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .rgb_i   (sq_rgb),
    .lq_i    (sq_root),
    .valid_o (dv_valid),
    .rgb_o   (dv_rgb),
    .lq_o    (dv_lq),
    .norm_o  (dv_norm)
  );

  rthl_class u_class (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (dv_valid),
    .rgb_i           (dv_rgb),
    .lq_i            (dv_lq),
    .norm_i          (dv_norm),
    .valid_o         (valid_o),
    .palette_index_o (palette_index_o),
    .hue_index_o     (hue_index_o),
    .level_o         (level_o)
  );

  a_index_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> palette_index_o == {hue_index_o, level_o})
    else $error("palette index does not match hue and level");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("held result dropped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("input stalled with empty output");

endmodule

FILE: sv/rthl_sqrt.sv
// ----------------------------------------------------------------------------
// rthl_sqrt: pipelined magnitude root
// Restoring square root of (r^2+g^2+b^2) scaled by 2^(2F), one result bit
// per register stage.
// ----------------------------------------------------------------------------
module rthl_sqrt import rthl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rgb_t            rgb_i,
  input  logic [SUMW-1:0] sum_i,
  output logic            valid_o,
  output rgb_t            rgb_o,
  output root_t           root_o
);

  localparam int RW = LW + 3;

  logic [RW-1:0] rem_q  [LW];
  root_t         root_q [LW];
  logic [XW-1:0] x_q    [LW];
  rgb_t          rgb_q  [LW];
  logic          v_q    [LW];

  for (genvar i = 0; i < LW; i++) begin : g_step
    logic [RW-1:0] rem_in;
    root_t         root_in;
    logic [XW-1:0] x_in;
    logic          v_in;
    rgb_t          rgb_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = {sum_i, {(2 * FRACTION_BITS){1'b0}}};
      assign v_in    = valid_i;
      assign rgb_in  = rgb_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
      assign v_in    = v_q[i-1];
      assign rgb_in  = rgb_q[i-1];
    end

    assign cur   = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (cur - trial) : cur;
        root_q[i] <= {root_in[LW-2:0], ge};
        x_q[i]    <= {x_in[XW-3:0], 2'b00};
        rgb_q[i]  <= rgb_in;
      end
    end
  end

  assign valid_o = v_q[LW-1];
  assign rgb_o   = rgb_q[LW-1];
  assign root_o  = root_q[LW-1];

endmodule

FILE: sv/rthl_div.sv
// ----------------------------------------------------------------------------
// rthl_div: pipelined normalizing divider
// Three restoring divider lanes compute c * 2^(2F) / Lq for red, green and
// blue, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rthl_div import rthl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rgb_t             rgb_i,
  input  root_t            lq_i,
  output logic             valid_o,
  output rgb_t             rgb_o,
  output root_t            lq_o,
  output logic [2:0][QW-1:0] norm_o
);

  logic [2:0][LW-1:0] rem_q [QW];
  logic [2:0][QW-1:0] q_q   [QW];
  root_t              lq_q  [QW];
  rgb_t               rgb_q [QW];
  logic               v_q   [QW];

  logic [2:0][7:0] comp;
  assign comp = {rgb_i.blue, rgb_i.green, rgb_i.red};

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [2:0][LW-1:0] rem_in;
    logic [2:0][QW-1:0] q_in;
    root_t              lq_in;
    rgb_t               rgb_in;
    logic               v_in;
    logic [2:0][LW-1:0] rem_nx;
    logic [2:0][QW-1:0] q_nx;

    if (i == 0) begin : g_first
      for (genvar c = 0; c < 3; c++) begin : g_lane
        // low dividend bits are all zero: start from c * 2^(F-2)
        assign rem_in[c] = LW'(comp[c]) << (FRACTION_BITS - 2);
      end
      assign q_in   = '0;
      assign lq_in  = lq_i;
      assign rgb_in = rgb_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign q_in   = q_q[i-1];
      assign lq_in  = lq_q[i-1];
      assign rgb_in = rgb_q[i-1];
      assign v_in   = v_q[i-1];
    end

    for (genvar c = 0; c < 3; c++) begin : g_calc
      logic [LW:0] cur;
      logic        ge;
      assign cur       = {rem_in[c], 1'b0};
      assign ge        = (cur >= {1'b0, lq_in});
      assign rem_nx[c] = ge ? LW'(cur - {1'b0, lq_in}) : LW'(cur);
      assign q_nx[c]   = {q_in[c][QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_nx;
        q_q[i]   <= q_nx;
        lq_q[i]  <= lq_in;
        rgb_q[i] <= rgb_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign rgb_o   = rgb_q[QW-1];
  assign lq_o    = lq_q[QW-1];
  assign norm_o  = q_q[QW-1];

endmodule

FILE: sv/rthl_class.sv
// ----------------------------------------------------------------------------
// rthl_class: hue and level classifier
// Orders the normalized color, scores five color forms by squared error,
// maps the winner to a hue vector and grades the magnitude into a level.
// ----------------------------------------------------------------------------
module rthl_class import rthl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rgb_t               rgb_i,
  input  root_t              lq_i,
  input  logic [2:0][QW-1:0] norm_i,
  output logic               valid_o,
  output logic [7:0]         palette_index_o,
  output logic [3:0]         hue_index_o,
  output logic [3:0]         level_o
);

  logic [4:0] v_q;

  // stage 1: order and absolute differences
  ord_e  ord_d;
  norm_t srt [3];
  norm_t nrm [3];
  norm_t dif_d [5][3];
  norm_t dif_q [5][3];
  ord_e  ord1_q, ord2_q, ord3_q;
  root_t lq1_q, lq2_q, lq3_q, lq4_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm[j] = (lq_i == '0) ? form_val(4, 0) : norm_i[j];
    end
    if (rgb_i.red >= rgb_i.green) begin
      if (rgb_i.red >= rgb_i.blue) begin
        ord_d = (rgb_i.green >= rgb_i.blue) ? ORD_RGB : ORD_RBG;
      end else begin
        ord_d = ORD_BRG;
      end
    end else begin
      if (rgb_i.green >= rgb_i.blue) begin
        ord_d = (rgb_i.red >= rgb_i.blue) ? ORD_GRB : ORD_GBR;
      end else begin
        ord_d = ORD_BGR;
      end
    end
    case (ord_d)
      ORD_RGB: begin srt[0] = nrm[0]; srt[1] = nrm[1]; srt[2] = nrm[2]; end
      ORD_RBG: begin srt[0] = nrm[0]; srt[1] = nrm[2]; srt[2] = nrm[1]; end
      ORD_BRG: begin srt[0] = nrm[2]; srt[1] = nrm[0]; srt[2] = nrm[1]; end
      ORD_GRB: begin srt[0] = nrm[1]; srt[1] = nrm[0]; srt[2] = nrm[2]; end
      ORD_GBR: begin srt[0] = nrm[1]; srt[1] = nrm[2]; srt[2] = nrm[0]; end
      default: begin srt[0] = nrm[2]; srt[1] = nrm[1]; srt[2] = nrm[0]; end
    endcase
    for (int f = 0; f < 5; f++) begin
      for (int j = 0; j < 3; j++) begin
        dif_d[f][j] = (form_val(f, j) >= srt[j]) ? (form_val(f, j) - srt[j])
                                                 : (srt[j] - form_val(f, j));
      end
    end
  end

  // stage 2: squares
  logic [2*QW-1:0] sq_q [5][3];
  // stage 3: form errors
  logic [EW-1:0]   err_q [5];
  // stage 4: winning hue
  logic [3:0]      hue_d, hue4_q;
  logic [EW-1:0]   best;
  logic [2:0]      form;
  // stage 5: level
  root_t           mq;
  logic [3:0]      cnt;
  logic [3:0]      level_d;

  always_comb begin
    best = err_q[0];
    form = 3'd0;
    for (int f = 1; f < 5; f++) begin
      if (err_q[f] < best) begin
        best = err_q[f];
        form = 3'(f);
      end
    end
    hue_d = HUE_MAP[ord3_q][form];
  end

  always_comb begin
    mq  = mag_frac(hue4_q);
    cnt = '0;
    for (int k = 1; k < 16; k++) begin
      if ({lq4_q, 4'b0000} >= TW'(k) * TW'(mq)) begin
        cnt = cnt + 4'd1;
      end
    end
    if (lq4_q >= mq) begin
      level_d = 4'd15;
    end else if (cnt == 4'd0) begin
      level_d = 4'd0;
    end else begin
      level_d = cnt - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q  <= dif_d;
      ord1_q <= ord_d;
      lq1_q  <= lq_i;
      for (int f = 0; f < 5; f++) begin
        for (int j = 0; j < 3; j++) begin
          sq_q[f][j] <= dif_q[f][j] * dif_q[f][j];
        end
        err_q[f] <= EW'(sq_q[f][0]) + EW'(sq_q[f][1]) + EW'(sq_q[f][2]);
      end
      ord2_q          <= ord1_q;
      lq2_q           <= lq1_q;
      ord3_q          <= ord2_q;
      lq3_q           <= lq2_q;
      hue4_q          <= hue_d;
      lq4_q           <= lq3_q;
      hue_index_o     <= hue4_q;
      level_o         <= level_d;
      palette_index_o <= {hue4_q, level_d};
    end
  end

  assign valid_o = v_q[4];

endmodule

FILE: verif/tb_rgb_to_hue_level_palette_index.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hue_level_palette_index: palette index pipeline testbench
// Drives RGB colors through the valid/stall handshake. A table of directed
// colors comes first, then random colors. Every result is compared, in order,
// with an integer model of the hue choice and brightness level, or with the index typed in the table.
// ----------------------------------------------------------------------------
module tb_rgb_to_hue_level_palette_index;
  import rthl_pkg::*;

  localparam int FB = rthl_pkg::FRACTION_BITS;
  localparam int SH = 24 - FB;
  localparam int N_RANDOM = 1425;
  localparam int WATCHDOG = 3000;

  typedef struct {
    logic [7:0] idx;
    logic [3:0] hue;
    logic [3:0] lvl;
  } pal_t;

  typedef struct {
    logic [7:0] r, g, b;
    bit         typed;
    logic [7:0] idx;
  } color_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       valid_i = 1'b0;
  logic       stall_o;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0;
  logic       valid_o;
  logic       stall_i = 1'b0;
  logic [7:0] palette_index_o;
  logic [3:0] hue_index_o;
  logic [3:0] level_o;

  pal_t pending_idx_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_rx = 1'b0;

  // form components in 2^-24 units, per form: max, mid, min
  const logic [63:0] FORM_TAB [5][3] = '{
    '{64'd16777216, 64'd0, 64'd0},
    '{64'd14680064, 64'd8122234, 64'd0},
    '{64'd11863284, 64'd11863284, 64'd0},
    '{64'd11184811, 64'd8842370, 64'd8842370},
    '{64'd9686331, 64'd9686331, 64'd9686331}
  };
  const logic [3:0] HUE_OF [6][5] = '{
    '{4'd12, 4'd14, 4'd10, 4'd15, 4'd0},
    '{4'd12, 4'd13, 4'd5,  4'd15, 4'd0},
    '{4'd1,  4'd4,  4'd5,  4'd6,  4'd0},
    '{4'd7,  4'd9,  4'd10, 4'd11, 4'd0},
    '{4'd7,  4'd8,  4'd3,  4'd11, 4'd0},
    '{4'd1,  4'd2,  4'd3,  4'd6,  4'd0}
  };
  const logic [63:0] MAG_TAB [16] = '{
    64'd7410042182, 64'd4278190080, 64'd4889360084, 64'd6050274209,
    64'd4889360084, 64'd6050274209, 64'd6417284801, 64'd4278190080,
    64'd4889360084, 64'd4889360084, 64'd6050274209, 64'd6417284801,
    64'd4278190080, 64'd4889360084, 64'd4889360084, 64'd6417284801
  };

  rgb_to_hue_level_palette_index u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] scale_const(input logic [63:0] v);
    if (SH == 0) return v;
    return (v + (64'd1 << (SH - 1))) >> SH;
  endfunction

  function automatic logic [63:0] absdiff_sq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic pal_t palette_of(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [63:0] sum, x, root, t, nr, ng, nb, hi, mid, lo, e, best, mq, lv;
    ord_e ord;
    int form;
    pal_t p;
    sum = 64'(r) * 64'(r) + 64'(g) * 64'(g) + 64'(b) * 64'(b);
    x = sum << (2 * FB);
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      t = root | (64'd1 << i);
      if (t * t <= x) root = t;
    end
    if (sum != 0) begin
      nr = (64'(r) << (2 * FB)) / root;
      ng = (64'(g) << (2 * FB)) / root;
      nb = (64'(b) << (2 * FB)) / root;
    end else begin
      nr = scale_const(FORM_TAB[4][0]);
      ng = nr;
      nb = nr;
    end
    // order on raw components, red/green tested first
    if (r >= g) begin
      if (r >= b) begin
        if (g >= b) begin ord = ORD_RGB; hi = nr; mid = ng; lo = nb; end
        else begin ord = ORD_RBG; hi = nr; mid = nb; lo = ng; end
      end else begin ord = ORD_BRG; hi = nb; mid = nr; lo = ng; end
    end else begin
      if (g >= b) begin
        if (r >= b) begin ord = ORD_GRB; hi = ng; mid = nr; lo = nb; end
        else begin ord = ORD_GBR; hi = ng; mid = nb; lo = nr; end
      end else begin ord = ORD_BGR; hi = nb; mid = ng; lo = nr; end
    end
    best = 0;
    form = 0;
    for (int f = 0; f < 5; f++) begin
      e = absdiff_sq(scale_const(FORM_TAB[f][0]), hi)
        + absdiff_sq(scale_const(FORM_TAB[f][1]), mid)
        + absdiff_sq(scale_const(FORM_TAB[f][2]), lo);
      if (f == 0 || e < best) begin best = e; form = f; end
    end
    p.hue = HUE_OF[ord][form];
    mq = scale_const(MAG_TAB[p.hue]);
    if (root >= mq) lv = 15;
    else begin
      lv = (16 * root) / mq;
      if (lv != 0) lv = lv - 1;
    end
    p.lvl = lv[3:0];
    p.idx = {p.hue, p.lvl};
    return p;
  endfunction

  task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input bit typed, input logic [7:0] typed_idx);
    pal_t p;
    p = palette_of(r, g, b);
    if (typed) begin
      p.idx = typed_idx;
      p.hue = typed_idx[7:4];
      p.lvl = typed_idx[3:0];
    end
    valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    pending_idx_q.push_back(p);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // compare each transaction with the oldest expectation
  always @(posedge clk_i) begin
    pal_t e;
    if (rst_ni && valid_o === 1'b1 && stall_i === 1'b0) begin
      if (pending_idx_q.size() == 0) begin
        $display("%0t: unexpected result, actual index %0d", $time, palette_index_o);
        errors++;
      end else begin
        e = pending_idx_q.pop_front();
        if (palette_index_o !== e.idx) begin
          $display("%0t: palette_index expected %0d actual %0d", $time, e.idx,
                   palette_index_o);
          errors++;
        end
        if (hue_index_o !== e.hue) begin
          $display("%0t: hue_index expected %0d actual %0d", $time, e.hue, hue_index_o);
          errors++;
        end
        if (level_o !== e.lvl) begin
          $display("%0t: level expected %0d actual %0d", $time, e.lvl, level_o);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        stall_i <= 1'b0;
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && stall_o === 1'b0) || (valid_o === 1'b1 && !stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    color_row_t rows[$];
    logic [7:0] r, g, b;
    rows = '{
      '{8'd0, 8'd0, 8'd0, 1'b1, 8'h00},
      '{8'd255, 8'd255, 8'd255, 1'b1, 8'h0F},
      '{8'd255, 8'd0, 8'd0, 1'b1, 8'hCF},
      '{8'd0, 8'd255, 8'd0, 1'b1, 8'h7F},
      '{8'd0, 8'd0, 8'd255, 1'b1, 8'h1F},
      '{8'd1, 8'd0, 8'd0, 1'b0, 8'h00},
      '{8'd0, 8'd1, 8'd0, 1'b0, 8'h00},
      '{8'd0, 8'd0, 8'd1, 1'b0, 8'h00},
      '{8'd1, 8'd1, 8'd1, 1'b0, 8'h00},
      '{8'd255, 8'd255, 8'd0, 1'b0, 8'h00},
      '{8'd255, 8'd0, 8'd255, 1'b0, 8'h00},
      '{8'd0, 8'd255, 8'd255, 1'b0, 8'h00},
      '{8'd200, 8'd100, 8'd50, 1'b0, 8'h00},
      '{8'd200, 8'd50, 8'd100, 1'b0, 8'h00},
      '{8'd100, 8'd50, 8'd200, 1'b0, 8'h00},
      '{8'd100, 8'd200, 8'd50, 1'b0, 8'h00},
      '{8'd50, 8'd200, 8'd100, 1'b0, 8'h00},
      '{8'd50, 8'd100, 8'd200, 1'b0, 8'h00},
      '{8'd128, 8'd128, 8'd64, 1'b0, 8'h00},
      '{8'd64, 8'd128, 8'd128, 1'b0, 8'h00},
      '{8'd128, 8'd64, 8'd128, 1'b0, 8'h00},
      '{8'd254, 8'd253, 8'd127, 1'b0, 8'h00},
      '{8'd170, 8'd85, 8'd85, 1'b0, 8'h00},
      '{8'd127, 8'd127, 8'd127, 1'b0, 8'h00},
      '{8'd3, 8'd2, 8'd1, 1'b0, 8'h00}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      maybe_gap();
      send_color(rows[i].r, rows[i].g, rows[i].b, rows[i].typed, rows[i].idx);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_rx = 1'b1;
      if (n == 700) begin
        // drain before resuming
        valid_i <= 1'b0;
        wait (pending_idx_q.size() == 0);
        @(posedge clk_i);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      case ($urandom_range(0, 4))
        0: begin r = 8'($urandom_range(0, 15)); g = 8'($urandom_range(0, 15));
                 b = 8'($urandom_range(0, 15)); end
        1: begin r = 8'($urandom); g = r; b = 8'($urandom); end
        2: begin r = 8'($urandom); g = 8'($urandom);
                 b = ($urandom_range(0, 1)) ? r : g; end
        3: begin r = $urandom_range(0, 1) ? 8'd255 : 8'($urandom);
                 g = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
                 b = $urandom_range(0, 1) ? 8'd255 : 8'($urandom); end
        default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
      endcase
      maybe_gap();
      send_color(r, g, b, 1'b0, 8'h00);
    end
    valid_i <= 1'b0;
    wait (pending_idx_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: rgb_to_hue_level_palette_index.f
sv/rthl_pkg.sv
sv/rthl_sqrt.sv
sv/rthl_div.sv
sv/rthl_class.sv
sv/rgb_to_hue_level_palette_index.sv
verif/tb_rgb_to_hue_level_palette_index.sv
